// ===== sv/tgdf_pkg.sv =====
// ----------------------------------------------------------------------------
// tgdf_pkg
// Shared types and constants for the thousands-grouped decimal formatter.
// ----------------------------------------------------------------------------
package tgdf_pkg;

  localparam int VALUE_W        = 64;
  localparam int CHAR_W         = 8;
  localparam int IDX_W          = 5;
  localparam int GRP_W          = 2;
  localparam int MAX_DIGITS_DEF = 20;
  localparam int GROUP_LEN      = 3;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

  typedef enum logic [1:0] {
    CV_IDLE,
    CV_RUN,
    CV_SCAN
  } conv_state_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_SIGN,
    EM_DIGIT,
    EM_COMMA
  } emit_state_t;

  // Handoff from converter to emitter.
  typedef struct packed {
    logic             done;
    logic             neg;
    logic [IDX_W-1:0] cnt;
    logic [GRP_W-1:0] grp;
  } conv_result_t;

endpackage

// ===== sv/tgdf_if.sv =====
// ----------------------------------------------------------------------------
// tgdf_in_if / tgdf_out_if
// Valid/ready channels for the input value and the output characters.
// ----------------------------------------------------------------------------
interface tgdf_in_if import tgdf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface tgdf_out_if import tgdf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ===== sv/tgdf_conv.sv =====
// ----------------------------------------------------------------------------
// tgdf_conv
// Shift-and-add-3 binary to BCD converter, one bit per cycle, followed by
// a scan for the leading significant digit.
// ----------------------------------------------------------------------------
module tgdf_conv import tgdf_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [VALUE_W-1:0]  value,
  output logic                idle,
  output conv_result_t        res,
  output logic [3:0]          digits [MAX_DIGITS]
);

  localparam int STEP_W = $clog2(VALUE_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VALUE_W - 1);

  conv_state_t        state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [VALUE_W-1:0] bin_r, bin_nxt;
  logic [3:0]         dig_r   [MAX_DIGITS];
  logic [3:0]         dig_nxt [MAX_DIGITS];
  logic [3:0]         adj     [MAX_DIGITS];
  logic               neg_r, neg_nxt;
  logic               ovf_r, ovf_nxt;
  logic [IDX_W-1:0]   cnt_c;
  logic [GRP_W-1:0]   grp_c;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CV_IDLE: if (start) state_nxt = CV_RUN;
      CV_RUN:  if (step_r == LAST_STEP) state_nxt = CV_SCAN;
      CV_SCAN: state_nxt = CV_IDLE;
      default: state_nxt = CV_IDLE;
    endcase
  end

  // datapath: one dabble step per cycle
  always_comb begin
    for (int k = 0; k < MAX_DIGITS; k++) begin
      adj[k] = (dig_r[k] >= 4'd5) ? dig_r[k] + 4'd3 : dig_r[k];
    end
    step_nxt = step_r;
    bin_nxt  = bin_r;
    neg_nxt  = neg_r;
    ovf_nxt  = ovf_r;
    dig_nxt  = dig_r;
    case (state_r)
      CV_IDLE: begin
        if (start) begin
          neg_nxt  = value[VALUE_W-1];
          bin_nxt  = value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;
          step_nxt = '0;
          ovf_nxt  = 1'b0;
          for (int k = 0; k < MAX_DIGITS; k++) dig_nxt[k] = 4'd0;
        end
      end
      CV_RUN: begin
        // carries out of the top digit drop: keeps the value mod 10^MAX_DIGITS
        dig_nxt[0] = {adj[0][2:0], bin_r[VALUE_W-1]};
        for (int k = 1; k < MAX_DIGITS; k++) dig_nxt[k] = {adj[k][2:0], adj[k-1][3]};
        if (adj[MAX_DIGITS-1][3]) ovf_nxt = 1'b1;
        bin_nxt  = {bin_r[VALUE_W-2:0], 1'b0};
        step_nxt = step_r + STEP_W'(1);
      end
      default: ;
    endcase
  end

  // leading digit search; zero still gives one digit
  always_comb begin
    cnt_c = IDX_W'(1);
    grp_c = '0;
    for (int j = 0; j < MAX_DIGITS; j++) begin
      if (dig_r[j] != 4'd0) begin
        cnt_c = IDX_W'(j + 1);
        grp_c = GRP_W'(j % GROUP_LEN);
      end
    end
    // value did not fit: every digit is shown, leading zeros included
    if (ovf_r) begin
      cnt_c = IDX_W'(MAX_DIGITS);
      grp_c = GRP_W'((MAX_DIGITS - 1) % GROUP_LEN);
    end
  end

  // outputs
  always_comb begin
    idle     = (state_r == CV_IDLE);
    res.done = (state_r == CV_SCAN);
    res.neg  = neg_r;
    res.cnt  = cnt_c;
    res.grp  = grp_c;
    digits   = dig_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CV_IDLE;
      neg_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      neg_r   <= neg_nxt;
    end
    step_r <= step_nxt;
    bin_r  <= bin_nxt;
    ovf_r  <= ovf_nxt;
    dig_r  <= dig_nxt;
  end

endmodule

// ===== sv/tgdf_emit.sv =====
// ----------------------------------------------------------------------------
// tgdf_emit
// Character sequencer: sign, digits most significant first, commas between
// groups of three. Drives a registered output word.
// ----------------------------------------------------------------------------
module tgdf_emit import tgdf_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  conv_result_t   res,
  input  logic [3:0]     digits [MAX_DIGITS],
  output logic           idle,
  tgdf_out_if.source     out_chan
);

  localparam int RD_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  emit_state_t       state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [GRP_W-1:0]  grp_r, grp_nxt;
  logic              vld_r, vld_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic              last_r, last_nxt;
  logic              adv;
  logic [IDX_W-1:0]  idx_dec;
  logic [3:0]        cur_dig;
  logic              comma_next;

  assign adv        = !vld_r || out_chan.ready;
  assign idx_dec    = idx_r - IDX_W'(1);
  assign cur_dig    = digits[idx_dec[RD_W-1:0]];
  assign comma_next = (idx_r > IDX_W'(1)) && (grp_r == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      EM_IDLE:  if (res.done) state_nxt = res.neg ? EM_SIGN : EM_DIGIT;
      EM_SIGN:  if (adv) state_nxt = EM_DIGIT;
      EM_DIGIT: begin
        if (adv) begin
          if (comma_next)              state_nxt = EM_COMMA;
          else if (idx_r == IDX_W'(1)) state_nxt = EM_IDLE;
        end
      end
      EM_COMMA: if (adv) state_nxt = EM_DIGIT;
      default:  state_nxt = EM_IDLE;
    endcase
  end

  // outputs and counters
  always_comb begin
    idx_nxt  = idx_r;
    grp_nxt  = grp_r;
    char_nxt = char_r;
    last_nxt = last_r;
    vld_nxt  = vld_r && !out_chan.ready;
    case (state_r)
      EM_IDLE: begin
        if (res.done) begin
          idx_nxt = res.cnt;
          grp_nxt = res.grp;
        end
      end
      EM_SIGN: begin
        if (adv) begin
          vld_nxt  = 1'b1;
          char_nxt = CHAR_MINUS;
          last_nxt = 1'b0;
        end
      end
      EM_DIGIT: begin
        if (adv) begin
          vld_nxt  = 1'b1;
          char_nxt = CHAR_ZERO + CHAR_W'(cur_dig);
          last_nxt = (idx_r == IDX_W'(1));
          if (!comma_next && idx_r != IDX_W'(1)) begin
            idx_nxt = idx_dec;
            grp_nxt = grp_r - GRP_W'(1);
          end
        end
      end
      EM_COMMA: begin
        if (adv) begin
          vld_nxt  = 1'b1;
          char_nxt = CHAR_COMMA;
          last_nxt = 1'b0;
          idx_nxt  = idx_dec;
          grp_nxt  = GRP_W'(GROUP_LEN - 1);
        end
      end
      default: ;
    endcase
  end

  assign idle               = (state_r == EM_IDLE);
  assign out_chan.valid     = vld_r;
  assign out_chan.char_code = char_r;
  assign out_chan.last_char = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EM_IDLE;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
    end
    idx_r  <= idx_nxt;
    grp_r  <= grp_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

endmodule

// ===== sv/thousands_grouped_decimal_formatter.sv =====
// Path from accepted value to first character: 64 dabble steps, the digit scan,
//   then the output register load from the emitter's sign or digit state.
// Values: one at a time through the shift-and-add-3 converter and the emitter;
//   each gives N characters (1..26), and a stalled output holds the emitter.
// Next value is accepted while the last character still waits in the output register.
// Reset: synchronous, active low; sequencers go idle and the output word is dropped.
// ----------------------------------------------------------------------------
// thousands_grouped_decimal_formatter
// Signed 64-bit integer to ASCII decimal with comma thousands separators.
// ----------------------------------------------------------------------------
module thousands_grouped_decimal_formatter import tgdf_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tgdf_in_if.sink    in_chan,
  tgdf_out_if.source out_chan
);

  conv_result_t conv_res;
  logic [3:0]   digits [MAX_DIGITS];
  logic         conv_idle;
  logic         emit_idle;
  logic         start;

  assign in_chan.ready = conv_idle && emit_idle;
  assign start         = in_chan.valid && in_chan.ready;

  tgdf_conv #(.MAX_DIGITS(MAX_DIGITS)) u_conv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .value  (in_chan.value),
    .idle   (conv_idle),
    .res    (conv_res),
    .digits (digits)
  );

  tgdf_emit #(.MAX_DIGITS(MAX_DIGITS)) u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (conv_res),
    .digits   (digits),
    .idle     (emit_idle),
    .out_chan (out_chan)
  );

endmodule

// ===== sv/tgdf_checker.sv =====
// ----------------------------------------------------------------------------
// tgdf_checker
// Port-level checks on the formatter, bound to the top level.
// ----------------------------------------------------------------------------
module tgdf_checker import tgdf_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] out_char,
  input logic              out_last
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("output word changed while stalled");

  // reset drops the output word
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a number never ends on a separator or sign
  a_comma_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_char == CHAR_COMMA) |-> !out_last)
    else $error("comma flagged as last character");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_char == CHAR_MINUS) |-> !out_last)
    else $error("minus flagged as last character");

  // ready for a new value only once the previous number's last character is in the output word
  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_last)
    else $error("input ready while a number is still being emitted");

endmodule

bind thousands_grouped_decimal_formatter tgdf_checker u_tgdf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_char  (out_chan.char_code),
  .out_last  (out_chan.last_char)
);
